/* src/apufs_pkg.sv */
package apufs_pkg;

   // Item operation codes
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_STATUS = 2'd1,
      OP_STEP   = 2'd2
   } opcode_type;

   // Register offsets from the base of the sound unit
   localparam logic [4:0] OFF_TRI_LINEAR   = 5'h08;
   localparam logic [4:0] OFF_TRI_LO       = 5'h0A;
   localparam logic [4:0] OFF_TRI_HI       = 5'h0B;
   localparam logic [4:0] OFF_NOISE_CTRL   = 5'h0C;
   localparam logic [4:0] OFF_NOISE_PERIOD = 5'h0E;
   localparam logic [4:0] OFF_NOISE_LEN    = 5'h0F;
   localparam logic [4:0] OFF_STATUS       = 5'h15;

   // Register index within one pulse channel
   localparam logic [1:0] PULSE_CTRL  = 2'd0;
   localparam logic [1:0] PULSE_SWEEP = 2'd1;
   localparam logic [1:0] PULSE_LO    = 2'd2;
   localparam logic [1:0] PULSE_HI    = 2'd3;

   // Channel numbers for length counters and enables
   localparam int CH_P1    = 0;
   localparam int CH_P2    = 1;
   localparam int CH_TRI   = 2;
   localparam int CH_NOISE = 3;

   localparam logic [3:0] ENV_LEVEL_MAX = 4'd15;
   localparam logic [10:0] PERIOD_MIN   = 11'd8;

   // Length counter load table
   function automatic logic [7:0] len_tab(input logic [4:0] idx);
      logic [7:0] v;
      case (idx)
         5'd0:  v = 8'd10;
         5'd1:  v = 8'd254;
         5'd2:  v = 8'd20;
         5'd3:  v = 8'd2;
         5'd4:  v = 8'd40;
         5'd5:  v = 8'd4;
         5'd6:  v = 8'd80;
         5'd7:  v = 8'd6;
         5'd8:  v = 8'd160;
         5'd9:  v = 8'd8;
         5'd10: v = 8'd60;
         5'd11: v = 8'd10;
         5'd12: v = 8'd14;
         5'd13: v = 8'd12;
         5'd14: v = 8'd26;
         5'd15: v = 8'd14;
         5'd16: v = 8'd12;
         5'd17: v = 8'd16;
         5'd18: v = 8'd24;
         5'd19: v = 8'd18;
         5'd20: v = 8'd48;
         5'd21: v = 8'd20;
         5'd22: v = 8'd96;
         5'd23: v = 8'd22;
         5'd24: v = 8'd192;
         5'd25: v = 8'd24;
         5'd26: v = 8'd72;
         5'd27: v = 8'd26;
         5'd28: v = 8'd16;
         5'd29: v = 8'd28;
         5'd30: v = 8'd32;
         5'd31: v = 8'd30;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/nes_apu_frame_sequencer_control.sv */
// Control part of a sound unit with a 4-step frame sequencer. Each request is a
// register write, a status read or one sequencer step; every request gives one
// response built from the state after that request. A request is taken in every
// cycle and its response is registered in the output register; the
// path is one pass of short logic from the state registers through the update
// (length table, envelope, sweep add/subtract) into the state and response
// registers. The request side stalls only while a response waits under stall.
module nes_apu_frame_sequencer_control
   import apufs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_reg_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [3:0]  rsp_pulse1_volume,
   output logic [3:0]  rsp_pulse2_volume,
   output logic [3:0]  rsp_noise_volume,
   output logic [10:0] rsp_pulse1_period,
   output logic [10:0] rsp_pulse2_period,
   output logic        rsp_pulse1_muted,
   output logic        rsp_pulse2_muted,
   output logic        rsp_triangle_sounding,
   output logic [10:0] rsp_triangle_period,
   output logic [3:0]  rsp_noise_period_index
);

   // Channel state
   logic [1:0][7:0] p_ctrl_ff, p_ctrl_in;
   logic [1:0][7:0] p_sweep_ff, p_sweep_in;
   logic [1:0][7:0] p_lo_ff, p_lo_in;
   logic [1:0][2:0] p_hi_ff, p_hi_in;
   logic [7:0]      n_ctrl_ff, n_ctrl_in;
   logic [3:0]      n_period_ff, n_period_in;
   logic [7:0]      t_ctrl_ff, t_ctrl_in;
   logic [7:0]      t_lo_ff, t_lo_in;
   logic [2:0]      t_hi_ff, t_hi_in;
   logic [3:0]      enables_ff, enables_in;
   logic [3:0][7:0] len_ff, len_in;
   logic [2:0]      env_trig_ff, env_trig_in;
   logic [2:0][3:0] env_div_ff, env_div_in;
   logic [2:0][3:0] env_level_ff, env_level_in;
   logic [1:0][2:0] swp_cnt_ff, swp_cnt_in;
   logic [6:0]      lin_ff, lin_in;
   logic            lin_pend_ff, lin_pend_in;
   logic [1:0]      step_ff, step_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  status_ff, status_in;
   logic [2:0][3:0] vol_ff, vol_in;
   logic [1:0][10:0] per_ff, per_in;
   logic [1:0]  muted_ff, muted_in;
   logic        tri_snd_ff, tri_snd_in;
   logic [10:0] tri_per_ff, tri_per_in;
   logic [3:0]  n_idx_ff, n_idx_in;

   logic accept;

   // Take a request unless a response waits under stall
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Apply the request to the state
   always_comb begin
      logic        psel;
      logic [2:0][7:0] env_ctrl;
      logic [3:0]  halt;
      logic [10:0] period;
      logic [12:0] delta;
      logic [12:0] target;

      p_ctrl_in     = p_ctrl_ff;
      p_sweep_in    = p_sweep_ff;
      p_lo_in       = p_lo_ff;
      p_hi_in       = p_hi_ff;
      n_ctrl_in     = n_ctrl_ff;
      n_period_in   = n_period_ff;
      t_ctrl_in     = t_ctrl_ff;
      t_lo_in       = t_lo_ff;
      t_hi_in       = t_hi_ff;
      enables_in    = enables_ff;
      len_in        = len_ff;
      env_trig_in   = env_trig_ff;
      env_div_in    = env_div_ff;
      env_level_in  = env_level_ff;
      swp_cnt_in    = swp_cnt_ff;
      lin_in        = lin_ff;
      lin_pend_in   = lin_pend_ff;
      step_in       = step_ff;

      psel     = req_reg_offset[2];
      env_ctrl = {n_ctrl_ff, p_ctrl_ff[1], p_ctrl_ff[0]};
      halt     = {n_ctrl_ff[5], t_ctrl_ff[7], p_ctrl_ff[1][5], p_ctrl_ff[0][5]};
      period   = '0;
      delta    = '0;
      target   = '0;

      if (accept) begin
         case (opcode_type'(req_opcode))
            OP_WRITE: begin
               if (req_reg_offset[4:3] == 2'b00) begin
                  case (req_reg_offset[1:0])
                     PULSE_CTRL:  p_ctrl_in[psel] = req_write_data;
                     PULSE_SWEEP: p_sweep_in[psel] = req_write_data;
                     PULSE_LO:    p_lo_in[psel] = req_write_data;
                     PULSE_HI: begin
                        p_hi_in[psel] = req_write_data[2:0];
                        if (enables_ff[{1'b0, psel}])
                           len_in[{1'b0, psel}] = len_tab(req_write_data[7:3]);
                        env_trig_in[{1'b0, psel}] = 1'b1;
                     end
                     default: ;
                  endcase
               end else begin
                  case (req_reg_offset)
                     OFF_TRI_LINEAR: t_ctrl_in = req_write_data;
                     OFF_TRI_LO:     t_lo_in = req_write_data;
                     OFF_TRI_HI: begin
                        t_hi_in = req_write_data[2:0];
                        if (enables_ff[CH_TRI])
                           len_in[CH_TRI] = len_tab(req_write_data[7:3]);
                        lin_pend_in = 1'b1;
                     end
                     OFF_NOISE_CTRL:   n_ctrl_in = req_write_data;
                     OFF_NOISE_PERIOD: n_period_in = req_write_data[3:0];
                     OFF_NOISE_LEN: begin
                        if (enables_ff[CH_NOISE])
                           len_in[CH_NOISE] = len_tab(req_write_data[7:3]);
                        env_trig_in[2] = 1'b1;
                     end
                     OFF_STATUS: begin
                        enables_in = req_write_data[3:0];
                        for (int c = 0; c < 4; c++)
                           if (!req_write_data[c]) len_in[c] = 8'd0;
                     end
                     default: ;
                  endcase
               end
            end
            OP_STEP: begin
               // Clock the envelopes
               for (int e = 0; e < 3; e++) begin
                  if (env_trig_ff[e]) begin
                     env_trig_in[e]  = 1'b0;
                     env_level_in[e] = ENV_LEVEL_MAX;
                     env_div_in[e]   = env_ctrl[e][3:0];
                  end else if (env_div_ff[e] == 4'd0) begin
                     env_div_in[e] = env_ctrl[e][3:0];
                     if (env_level_ff[e] != 4'd0)
                        env_level_in[e] = env_level_ff[e] - 4'd1;
                     else if (env_ctrl[e][5])
                        env_level_in[e] = ENV_LEVEL_MAX;
                  end else begin
                     env_div_in[e] = env_div_ff[e] - 4'd1;
                  end
               end
               // Clock the triangle linear counter
               if (lin_pend_ff)
                  lin_in = t_ctrl_ff[6:0];
               else if (lin_ff != 7'd0)
                  lin_in = lin_ff - 7'd1;
               if (!t_ctrl_ff[7])
                  lin_pend_in = 1'b0;
               // Odd steps: length counters and sweeps
               if (step_ff[0]) begin
                  for (int c = 0; c < 4; c++)
                     if (len_ff[c] != 8'd0 && !halt[c])
                        len_in[c] = len_ff[c] - 8'd1;
                  for (int p = 0; p < 2; p++) begin
                     period = {p_hi_ff[p], p_lo_ff[p]};
                     delta  = {2'b00, period >> p_sweep_ff[p][2:0]};
                     if (p_sweep_ff[p][3])
                        target = {2'b00, period} - delta - 13'((p == 0) ? 1 : 0);
                     else
                        target = {2'b00, period} + delta;
                     if (p_sweep_ff[p][7]) begin
                        if (swp_cnt_ff[p] != 3'd0) begin
                           swp_cnt_in[p] = swp_cnt_ff[p] - 3'd1;
                        end else begin
                           swp_cnt_in[p] = p_sweep_ff[p][6:4];
                           if (target[12:11] == 2'b00 && target[10:3] != 8'd0) begin
                              p_lo_in[p] = target[7:0];
                              p_hi_in[p] = target[10:8];
                           end
                        end
                     end
                  end
               end
               step_in = step_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   // Build the response from the updated state
   always_comb begin
      logic [2:0][7:0] vctrl;
      logic [2:0]      vlen;
      logic [10:0]     period;
      logic [11:0]     target;

      vctrl = {n_ctrl_in, p_ctrl_in[1], p_ctrl_in[0]};
      vlen  = {len_in[CH_NOISE] != 8'd0, len_in[CH_P2] != 8'd0, len_in[CH_P1] != 8'd0};
      for (int c = 0; c < 4; c++)
         status_in[c] = (len_in[c] != 8'd0);
      for (int e = 0; e < 3; e++) begin
         if (!vlen[e])
            vol_in[e] = 4'd0;
         else if (vctrl[e][4])
            vol_in[e] = vctrl[e][3:0];
         else
            vol_in[e] = env_level_in[e];
      end
      for (int p = 0; p < 2; p++) begin
         period    = {p_hi_in[p], p_lo_in[p]};
         target    = {1'b0, period} + {1'b0, period >> p_sweep_in[p][2:0]};
         per_in[p] = period;
         muted_in[p] = (period < PERIOD_MIN) || target[11] || (vol_in[p] == 4'd0);
      end
      tri_per_in = {t_hi_in, t_lo_in};
      tri_snd_in = (len_in[CH_TRI] != 8'd0) && (lin_in != 7'd0) && (tri_per_in[10:1] != 10'd0);
      n_idx_in   = n_period_in;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   // Hold state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctrl_ff     <= '0;
         p_sweep_ff    <= '0;
         p_lo_ff       <= '0;
         p_hi_ff       <= '0;
         n_ctrl_ff     <= '0;
         n_period_ff   <= '0;
         t_ctrl_ff     <= '0;
         t_lo_ff       <= '0;
         t_hi_ff       <= '0;
         enables_ff    <= '0;
         len_ff        <= '0;
         env_trig_ff   <= '0;
         env_div_ff    <= '0;
         env_level_ff  <= '0;
         swp_cnt_ff    <= '0;
         lin_ff        <= '0;
         lin_pend_ff   <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         p_ctrl_ff     <= p_ctrl_in;
         p_sweep_ff    <= p_sweep_in;
         p_lo_ff       <= p_lo_in;
         p_hi_ff       <= p_hi_in;
         n_ctrl_ff     <= n_ctrl_in;
         n_period_ff   <= n_period_in;
         t_ctrl_ff     <= t_ctrl_in;
         t_lo_ff       <= t_lo_in;
         t_hi_ff       <= t_hi_in;
         enables_ff    <= enables_in;
         len_ff        <= len_in;
         env_trig_ff   <= env_trig_in;
         env_div_ff    <= env_div_in;
         env_level_ff  <= env_level_in;
         swp_cnt_ff    <= swp_cnt_in;
         lin_ff        <= lin_in;
         lin_pend_ff   <= lin_pend_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load the response payload on each transfer in
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         vol_ff     <= vol_in;
         per_ff     <= per_in;
         muted_ff   <= muted_in;
         tri_snd_ff <= tri_snd_in;
         tri_per_ff <= tri_per_in;
         n_idx_ff   <= n_idx_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_pulse1_volume      = vol_ff[0];
   assign rsp_pulse2_volume      = vol_ff[1];
   assign rsp_noise_volume       = vol_ff[2];
   assign rsp_pulse1_period      = per_ff[0];
   assign rsp_pulse2_period      = per_ff[1];
   assign rsp_pulse1_muted       = muted_ff[0];
   assign rsp_pulse2_muted       = muted_ff[1];
   assign rsp_triangle_sounding  = tri_snd_ff;
   assign rsp_triangle_period    = tri_per_ff;
   assign rsp_noise_period_index = n_idx_ff;

endmodule

/* src/apufs_checker.sv */
module apufs_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic [3:0]  rsp_pulse1_volume,
   input logic [3:0]  rsp_noise_volume,
   input logic        rsp_triangle_sounding,
   input logic [10:0] rsp_triangle_period
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every transfer in gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no response after request transfer");

   // A volume only sounds while its length counter runs
   a_vol_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pulse1_volume == 4'd0 || rsp_status[0]) &&
                    (rsp_noise_volume == 4'd0 || rsp_status[3]))
      else $error("volume with empty length counter");

   // The triangle sounds only with length and a usable period
   a_tri_snd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_triangle_sounding |->
         rsp_status[2] && rsp_triangle_period[10:1] != 10'd0)
      else $error("triangle sounding without length or period");

endmodule

bind nes_apu_frame_sequencer_control apufs_props u_apufs_props (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_pulse1_volume     (rsp_pulse1_volume),
   .rsp_noise_volume      (rsp_noise_volume),
   .rsp_triangle_sounding (rsp_triangle_sounding),
   .rsp_triangle_period   (rsp_triangle_period)
);

/* bench/apufs_checker.sv */
module apufs_checker
   import apufs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_reg_offset,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [3:0]  rsp_pulse1_volume,
   input  logic [3:0]  rsp_pulse2_volume,
   input  logic [3:0]  rsp_noise_volume,
   input  logic [10:0] rsp_pulse1_period,
   input  logic [10:0] rsp_pulse2_period,
   input  logic        rsp_pulse1_muted,
   input  logic        rsp_pulse2_muted,
   input  logic        rsp_triangle_sounding,
   input  logic [10:0] rsp_triangle_period,
   input  logic [3:0]  rsp_noise_period_index,
   output int          fail_count,
   output int          pending,
   output int          n_writes,
   output int          n_reads,
   output int          n_steps,
   output int          n_compared
);
   timeunit 1ns;
   timeprecision 1ps;

   // Envelope units
   localparam int ENV_P1    = 0;
   localparam int ENV_P2    = 1;
   localparam int ENV_NOISE = 2;

   localparam int PERIOD_MAX = 2047;

   // Length counter load values, indexed by the top five bits of the written byte
   localparam logic [0:31][7:0] LENGTH_LOAD = {
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  pulse1_volume;
      logic [3:0]  pulse2_volume;
      logic [3:0]  noise_volume;
      logic [10:0] pulse1_period;
      logic [10:0] pulse2_period;
      logic        pulse1_muted;
      logic        pulse2_muted;
      logic        triangle_sounding;
      logic [10:0] triangle_period;
      logic [3:0]  noise_period_index;
   } apu_outputs_type;

   // Shadow copy of the sound unit
   logic [7:0] pulse_reg [8];
   logic [7:0] noise_reg [4];
   logic [7:0] tri_reg [4];
   logic [3:0] enables;
   logic [7:0] len_ctr [4];
   logic       env_trig [3];
   logic [3:0] env_div [3];
   logic [3:0] env_level [3];
   logic [2:0] swp_cnt [2];
   logic [6:0] lin_ctr;
   logic [6:0] lin_value;
   logic       lin_flag;
   logic [1:0] step_cnt;

   apu_outputs_type apu_outputs_q [$];

   function automatic void clear_sound_unit();
      for (int i = 0; i < 8; i++) pulse_reg[i] = '0;
      for (int i = 0; i < 4; i++) begin
         noise_reg[i] = '0;
         tri_reg[i]   = '0;
         len_ctr[i]   = '0;
      end
      for (int i = 0; i < 3; i++) begin
         env_trig[i]  = 1'b0;
         env_div[i]   = '0;
         env_level[i] = '0;
      end
      swp_cnt[0]   = '0;
      swp_cnt[1]   = '0;
      enables      = '0;
      lin_ctr      = '0;
      lin_value    = '0;
      lin_flag     = 1'b0;
      step_cnt     = '0;
   endfunction

   function automatic logic [7:0] env_ctrl(int e);
      if (e == ENV_P1) return pulse_reg[0];
      if (e == ENV_P2) return pulse_reg[4];
      return noise_reg[0];
   endfunction

   // Load a length counter, only while its channel is enabled
   function automatic void load_length(int lc, logic [7:0] v);
      if (enables[lc]) len_ctr[lc] = LENGTH_LOAD[v[7:3]];
   endfunction

   function automatic void register_write(logic [4:0] a, logic [7:0] v);
      int p;
      p = a[2];
      if (a <= (OFF_TRI_LINEAR - 5'd1)) begin
         pulse_reg[a[2:0]] = v;
         if (a[1:0] == PULSE_HI) begin
            load_length(p, v);
            env_trig[p] = 1'b1;
         end
      end else begin
         case (a)
            OFF_TRI_LINEAR: begin
               tri_reg[0] = v;
               lin_value  = v[6:0];
            end
            OFF_TRI_LO: tri_reg[2] = v;
            OFF_TRI_HI: begin
               tri_reg[3] = v;
               load_length(CH_TRI, v);
               lin_flag = 1'b1;
            end
            OFF_NOISE_CTRL: noise_reg[0] = v;
            OFF_NOISE_PERIOD: noise_reg[2] = v;
            OFF_NOISE_LEN: begin
               noise_reg[3] = v;
               load_length(CH_NOISE, v);
               env_trig[ENV_NOISE] = 1'b1;
            end
            OFF_STATUS: begin
               enables = v[3:0];
               for (int i = 0; i < 4; i++)
                  if (!enables[i]) len_ctr[i] = '0;
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void tick_envelope(int e);
      logic [7:0] r0;
      r0 = env_ctrl(e);
      if (env_trig[e]) begin
         env_trig[e]  = 1'b0;
         env_level[e] = ENV_LEVEL_MAX;
         env_div[e]   = r0[3:0];
      end else if (env_div[e] == 0) begin
         env_div[e] = r0[3:0];
         if (env_level[e] != 0) env_level[e] = env_level[e] - 4'd1;
         else if (r0[5]) env_level[e] = ENV_LEVEL_MAX;
      end else begin
         env_div[e] = env_div[e] - 4'd1;
      end
   endfunction

   function automatic void tick_length(int lc, logic halt);
      if (len_ctr[lc] != 0 && !halt) len_ctr[lc] = len_ctr[lc] - 8'd1;
   endfunction

   // Sweep unit: pulse one subtracts one more than pulse two when negating
   function automatic void tick_sweep(int p);
      logic [7:0] s;
      int per;
      int delta;
      s = pulse_reg[p*4 + PULSE_SWEEP];
      if (!s[7]) return;
      if (swp_cnt[p] != 0) begin
         swp_cnt[p] = swp_cnt[p] - 3'd1;
         return;
      end
      swp_cnt[p] = s[6:4];
      per = {pulse_reg[p*4 + PULSE_HI][2:0], pulse_reg[p*4 + PULSE_LO]};
      delta = per >> s[2:0];
      if (s[3]) per = per - delta - ((p == CH_P1) ? 1 : 0);
      else per = per + delta;
      if (per < int'(PERIOD_MIN) || per > PERIOD_MAX) return;
      pulse_reg[p*4 + PULSE_LO] = per[7:0];
      pulse_reg[p*4 + PULSE_HI] = {pulse_reg[p*4 + PULSE_HI][7:3], per[10:8]};
   endfunction

   function automatic void sequencer_step();
      tick_envelope(ENV_P1);
      tick_envelope(ENV_P2);
      tick_envelope(ENV_NOISE);
      if (lin_flag) lin_ctr = lin_value;
      else if (lin_ctr != 0) lin_ctr = lin_ctr - 7'd1;
      if (!tri_reg[0][7]) lin_flag = 1'b0;
      // Odd steps clock length counters and sweeps
      if (step_cnt[0]) begin
         tick_length(CH_P1, pulse_reg[0][5]);
         tick_length(CH_P2, pulse_reg[4][5]);
         tick_length(CH_NOISE, noise_reg[0][5]);
         tick_length(CH_TRI, tri_reg[0][7]);
         tick_sweep(CH_P1);
         tick_sweep(CH_P2);
      end
      step_cnt = step_cnt + 2'd1;
   endfunction

   function automatic logic [3:0] channel_volume(int e, int lc);
      logic [7:0] r0;
      r0 = env_ctrl(e);
      if (len_ctr[lc] == 0) return 4'd0;
      return r0[4] ? r0[3:0] : env_level[e];
   endfunction

   function automatic logic [10:0] pulse_period(int p);
      return {pulse_reg[p*4 + PULSE_HI][2:0], pulse_reg[p*4 + PULSE_LO]};
   endfunction

   function automatic logic pulse_muted(int p, logic [3:0] vol);
      int per;
      int tgt;
      per = pulse_period(p);
      tgt = per + (per >> pulse_reg[p*4 + PULSE_SWEEP][2:0]);
      return (per < int'(PERIOD_MIN) || tgt > PERIOD_MAX || vol == 0);
   endfunction

   // Apply one item and return the outputs it leaves behind
   function automatic apu_outputs_type run_apu_item(logic [1:0] op, logic [4:0] a,
                                                    logic [7:0] v);
      apu_outputs_type r;
      logic [10:0]  tper;
      if (op == OP_WRITE) register_write(a, v);
      else if (op == OP_STEP) sequencer_step();
      tper = {tri_reg[3][2:0], tri_reg[2]};
      r.status = {len_ctr[CH_NOISE] != 0, len_ctr[CH_TRI] != 0,
                  len_ctr[CH_P2] != 0, len_ctr[CH_P1] != 0};
      r.pulse1_volume      = channel_volume(ENV_P1, CH_P1);
      r.pulse2_volume      = channel_volume(ENV_P2, CH_P2);
      r.noise_volume       = channel_volume(ENV_NOISE, CH_NOISE);
      r.pulse1_period      = pulse_period(CH_P1);
      r.pulse2_period      = pulse_period(CH_P2);
      r.pulse1_muted       = pulse_muted(CH_P1, r.pulse1_volume);
      r.pulse2_muted       = pulse_muted(CH_P2, r.pulse2_volume);
      r.triangle_sounding  = (len_ctr[CH_TRI] != 0) && (lin_ctr != 0) && (tper >= 11'd2);
      r.triangle_period    = tper;
      r.noise_period_index = noise_reg[2][3:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [10:0] exp_v, logic [10:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endfunction

   // Predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      apu_outputs_type e;
      if (reset) begin
         clear_sound_unit();
         apu_outputs_q.delete();
         pending = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apu_outputs_q.push_back(run_apu_item(req_opcode, req_reg_offset, req_write_data));
            if (req_opcode == OP_WRITE) n_writes++;
            else if (req_opcode == OP_STATUS) n_reads++;
            else if (req_opcode == OP_STEP) n_steps++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (apu_outputs_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               e = apu_outputs_q.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("pulse1_volume", e.pulse1_volume, rsp_pulse1_volume);
               check_field("pulse2_volume", e.pulse2_volume, rsp_pulse2_volume);
               check_field("noise_volume", e.noise_volume, rsp_noise_volume);
               check_field("pulse1_period", e.pulse1_period, rsp_pulse1_period);
               check_field("pulse2_period", e.pulse2_period, rsp_pulse2_period);
               check_field("pulse1_muted", e.pulse1_muted, rsp_pulse1_muted);
               check_field("pulse2_muted", e.pulse2_muted, rsp_pulse2_muted);
               check_field("triangle_sounding", e.triangle_sounding, rsp_triangle_sounding);
               check_field("triangle_period", e.triangle_period, rsp_triangle_period);
               check_field("noise_period_index", e.noise_period_index,
                           rsp_noise_period_index);
               n_compared++;
            end
         end
         pending = apu_outputs_q.size();
      end
   end

endmodule

/* bench/testbench.sv */
module testbench
   import apufs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [4:0] OFF_P1       = 5'h00;
   localparam logic [4:0] OFF_P2       = 5'h04;
   localparam logic [4:0] OFF_TRI_GAP  = 5'h09;
   localparam logic [4:0] OFF_DAC      = 5'h11;
   localparam logic [4:0] OFF_TOP      = 5'h1F;

   localparam int ITEMS_PER_PHASE = 670;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_STATUS;
   logic [4:0]  req_reg_offset = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [3:0]  rsp_pulse1_volume;
   logic [3:0]  rsp_pulse2_volume;
   logic [3:0]  rsp_noise_volume;
   logic [10:0] rsp_pulse1_period;
   logic [10:0] rsp_pulse2_period;
   logic        rsp_pulse1_muted;
   logic        rsp_pulse2_muted;
   logic        rsp_triangle_sounding;
   logic [10:0] rsp_triangle_period;
   logic [3:0]  rsp_noise_period_index;

   int fail_count;
   int pending;
   int n_writes;
   int n_reads;
   int n_steps;
   int n_compared;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int phase = 0;

   // Offsets that reach a channel register
   logic [4:0] channel_offsets [14] = '{
      5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06, 5'h07,
      OFF_TRI_LINEAR, OFF_TRI_LO, OFF_TRI_HI,
      OFF_NOISE_CTRL, OFF_NOISE_PERIOD, OFF_NOISE_LEN
   };

   nes_apu_frame_sequencer_control DUT (.*);

   apufs_checker apu_watch (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off in the last phase
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 3 && !held) begin
            held = 1'b1;
            repeat (HOLD_OFF_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one item, with optional idle cycles first, and hold it until transfer
   task automatic send_item(input logic [1:0] op, input logic [4:0] off,
                            input logic [7:0] dat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_reg_offset <= off;
      req_write_data <= dat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int roll;
      int pick;
      logic [1:0] op;
      logic [4:0] off;
      logic [7:0] dat;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: length load while disabled, extremes, sweeps, ignored items
      phase = 1;
      send_idle_pct = 35;
      recv_idle_pct = 73;
      send_item(OP_WRITE, OFF_P1 | PULSE_HI, 8'hF8);
      send_item(OP_STATUS, OFF_STATUS, 8'h00);
      send_item(OP_WRITE, OFF_STATUS, 8'h0F);
      send_item(OP_WRITE, OFF_P1 | PULSE_CTRL, 8'h3F);
      send_item(OP_WRITE, OFF_P1 | PULSE_SWEEP, 8'hFF);
      send_item(OP_WRITE, OFF_P1 | PULSE_LO, 8'hFF);
      send_item(OP_WRITE, OFF_P1 | PULSE_HI, 8'h0F);
      send_item(OP_WRITE, OFF_P2 | PULSE_CTRL, 8'h00);
      send_item(OP_WRITE, OFF_P2 | PULSE_SWEEP, 8'h81);
      send_item(OP_WRITE, OFF_P2 | PULSE_LO, 8'h00);
      send_item(OP_WRITE, OFF_P2 | PULSE_HI, 8'h07);
      send_item(OP_WRITE, OFF_TRI_LINEAR, 8'hFF);
      send_item(OP_WRITE, OFF_TRI_LO, 8'h01);
      send_item(OP_WRITE, OFF_TRI_HI, 8'h00);
      send_item(OP_WRITE, OFF_NOISE_CTRL, 8'h20);
      send_item(OP_WRITE, OFF_NOISE_PERIOD, 8'h8F);
      send_item(OP_WRITE, OFF_NOISE_LEN, 8'hFF);
      repeat (4) send_item(OP_STEP, OFF_TOP, 8'hFF);
      send_item(OP_WRITE, OFF_TRI_GAP, 8'hAA);
      send_item(OP_WRITE, OFF_DAC, 8'h55);
      send_item(OP_WRITE, OFF_TOP, 8'hFF);
      send_item(OP_UNUSED, OFF_STATUS, 8'h00);
      send_item(OP_WRITE, OFF_STATUS, 8'h00);
      send_item(OP_STATUS, OFF_P1, 8'h00);

      // Random: steps interleaved with channel writes, enables kept mostly on
      for (int ph = 1; ph <= 3; ph++) begin
         phase = ph;
         send_idle_pct = (ph == 1) ? 35 : (ph == 2) ? 73 : 0;
         recv_idle_pct = (ph == 1) ? 73 : (ph == 2) ? 35 : 0;
         repeat (ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            dat  = 8'($urandom_range(255));
            off  = 5'($urandom_range(31));
            if (roll < 40) begin
               op = OP_STEP;
            end else if (roll < 48) begin
               op = OP_STATUS;
            end else if (roll < 50) begin
               op = OP_UNUSED;
            end else begin
               op = OP_WRITE;
               pick = $urandom_range(99);
               if (pick < 8) begin
                  off = OFF_STATUS;
                  if ($urandom_range(3) != 0) dat = 8'h0F;
               end else if (pick >= 18) begin
                  off = channel_offsets[$urandom_range(13)];
               end
            end
            send_item(op, off, dat);
         end
      end

      // Drain outstanding responses
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d register writes, %0d status reads and %0d sequencer steps (%0d frames)",
               n_writes, n_reads, n_steps, n_steps / 4);
      $display("%0d responses compared across three stall mixes and one long response hold-off",
               n_compared);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
